### src/modular_inverse_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for modular_inverse_top
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_TOP_ASSERT_SVH
`define MODULAR_INVERSE_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define MI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mi_pkg.sv
// ----------------------------------------------------------------------------
// mi_pkg
// Types and constants shared by the modular inverse block.
// ----------------------------------------------------------------------------
package mi_pkg;

	localparam int DATA_WIDTH = 31;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic [DATA_WIDTH-1:0] modulus;
	} src_item_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] inverse;
		logic                  exists;
	} res_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic div_init;
		logic div_bit;
		logic update;
		logic reduce;
		logic emit;
	} mi_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic zero_in;
		logic r1_zero;
		logic bit_last;
		logic out_free;
	} mi_sts_t;

endpackage

### src/modular_inverse_top.sv
// ----------------------------------------------------------------------------
// modular_inverse_top
// Modular inverse by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// Input channel src (src_valid/src_stall/src_data) carries value and
// modulus; output channel res (res_valid/res_stall/res_data) carries
// inverse and exists. An item moves when valid is high and stall low.
// One item is worked on at a time: src_stall stays high from the cycle
// after acceptance until the sequencer is idle again.
// Each Euclid step is one divide pass over DATA_WIDTH quotient bits (one
// quotient bit per cycle from the shared restoring divider) plus setup
// and update. 31-bit operands need at most about 45 steps; an item with
// a zero operand needs none.
// The result sits in an output register; the next item is accepted while
// it waits. If res_stall holds, the following result waits in the last
// sequencer state until the register frees up.
// arst_n clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
module modular_inverse_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  mi_pkg::src_item_t src_data,
	output logic              res_valid,
	input  logic              res_stall,
	output mi_pkg::res_item_t res_data
);
	import mi_pkg::*;

	mi_cmd_t cmd;
	mi_sts_t sts;

	mi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

### src/mi_dp.sv
// ----------------------------------------------------------------------------
// mi_dp
// Datapath: Euclid remainder and coefficient registers, a restoring
// divider that retires one quotient bit per cycle while accumulating
// q*c1, final sign fix-up and the output register.
// ----------------------------------------------------------------------------
module mi_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mi_pkg::mi_cmd_t   cmd,
	output mi_pkg::mi_sts_t   sts,
	input  mi_pkg::src_item_t src_data,
	output logic              res_valid,
	input  logic              res_stall,
	output mi_pkg::res_item_t res_data
);
	import mi_pkg::*;

	logic [DATA_WIDTH-1:0] n_q, r0_q, r1_q, c0_q, c1_q;
	logic                  par_q, zero_q;
	logic [DATA_WIDTH-1:0] rem_q, d_q, acc_q;
	logic [CNT_W-1:0]      cnt_q;
	res_item_t             out_q;
	logic                  out_vld_q;

	logic [DATA_WIDTH:0]   sh;
	logic [DATA_WIDTH+1:0] diff;
	logic                  qbit;
	logic [DATA_WIDTH-1:0] rem_nxt, acc_nxt, mag_red, inv_val;
	logic                  ok;

	// one restoring-division step
	assign sh      = {rem_q, d_q[DATA_WIDTH-1]};
	assign diff    = {1'b0, sh} - {2'b00, r1_q};
	assign qbit    = ~diff[DATA_WIDTH+1];
	assign rem_nxt = qbit ? diff[DATA_WIDTH-1:0] : sh[DATA_WIDTH-1:0];
	// Horner form of q*c1, MSB first; does not exceed the modulus
	assign acc_nxt = {acc_q[DATA_WIDTH-2:0], 1'b0} + (qbit ? c1_q : '0);

	assign mag_red = (c0_q >= n_q) ? (c0_q - n_q) : c0_q;
	assign ok      = ~zero_q && (r0_q == DATA_WIDTH'(1));
	// even index means a negative coefficient
	assign inv_val = par_q ? c0_q : ((c0_q == '0) ? '0 : (n_q - c0_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= src_data.modulus;
			r0_q   <= src_data.modulus;
			r1_q   <= src_data.value;
			c0_q   <= '0;
			c1_q   <= DATA_WIDTH'(1);
			par_q  <= 1'b0;
			zero_q <= (src_data.value == '0) || (src_data.modulus == '0);
		end else if (cmd.update) begin
			r0_q  <= r1_q;
			r1_q  <= rem_q;
			c0_q  <= c1_q;
			c1_q  <= c0_q + acc_q;
			par_q <= ~par_q;
		end else if (cmd.reduce) begin
			c0_q <= mag_red;
		end

		if (cmd.div_init) begin
			rem_q <= '0;
			d_q   <= r0_q;
			acc_q <= '0;
		end else if (cmd.div_bit) begin
			rem_q <= rem_nxt;
			d_q   <= {d_q[DATA_WIDTH-2:0], 1'b0};
			acc_q <= acc_nxt;
		end

		if (cmd.emit) begin
			out_q.exists  <= ok;
			out_q.inverse <= ok ? inv_val : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_bit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (!res_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign sts.zero_in  = zero_q;
	assign sts.r1_zero  = (r1_q == '0);
	assign sts.bit_last = (cnt_q == CNT_W'(DATA_WIDTH - 1));
	assign sts.out_free = ~out_vld_q | ~res_stall;

	assign res_valid = out_vld_q;
	assign res_data  = out_q;

endmodule

### src/mi_ctrl.sv
// ----------------------------------------------------------------------------
// mi_ctrl
// Sequencer: loads an item, runs Euclid steps (one divide pass plus an
// update each), reduces the last coefficient and hands off the result.
// ----------------------------------------------------------------------------
module mi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            src_valid,
	output logic            src_stall,
	input  mi_pkg::mi_sts_t sts,
	output mi_pkg::mi_cmd_t cmd
);
	import mi_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOOP = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_UPD  = 6'b001000,
		ST_RED  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (sts.zero_in || sts.r1_zero) begin
					state_nxt = ST_RED;
				end else begin
					cmd.div_init = 1'b1;
					state_nxt    = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_bit = 1'b1;
				if (sts.bit_last) begin
					state_nxt = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_nxt  = ST_LOOP;
			end
			ST_RED: begin
				cmd.reduce = 1'b1;
				state_nxt  = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign src_stall = (state_q != ST_IDLE);

endmodule

### src/mi_checker.sv
// ----------------------------------------------------------------------------
// mi_checker
// Port-level checks for modular_inverse_top, attached by bind.
// ----------------------------------------------------------------------------
`include "modular_inverse_top_assert.svh"

module mi_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              src_valid,
	input logic              src_stall,
	input mi_pkg::src_item_t src_data,
	input logic              res_valid,
	input logic              res_stall,
	input mi_pkg::res_item_t res_data
);
	import mi_pkg::*;

	logic src_take;
	assign src_take = src_valid && !src_stall;

	`MI_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid, "result dropped under stall")
	`MI_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res_data), "result changed under stall")
	// one item in flight: intake closes right after an accept
	`MI_ASSERT_NEXT(a_one_item, src_take, src_stall, "second item taken while busy")
	`MI_ASSERT_NOW(a_no_inv_zero, res_valid && !res_data.exists, res_data.inverse == '0, "nonzero inverse without exists")

endmodule

bind modular_inverse_top mi_checker u_mi_checker (.*);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for modular_inverse_top. A clocked driver sends
// value/modulus items from a queue and predicts each inverse with its own
// extended Euclid routine. A clocked monitor checks every result in order.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mi_pkg::*;

	localparam int W         = DATA_WIDTH;
	localparam int PERIOD    = 10;
	localparam int LIMIT     = 5_000_000;
	localparam int TAIL      = 40;
	localparam int IDLE_PCT  = 25;
	localparam int BATCH     = 200;
	localparam logic [W-1:0] WMAX = {W{1'b1}};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	src_item_t src_data  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_data;

	src_item_t operand_q[$];
	res_item_t inverse_q[$];

	int src_idle_pct  = IDLE_PCT;
	int res_stall_pct = IDLE_PCT;
	int err_cnt       = 0;
	int n_accepted    = 0;
	int n_results     = 0;
	int n_exist       = 0;
	int cycle_cnt     = 0;

	modular_inverse_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

	always #(PERIOD/2) clk = ~clk;

	// Euclid on (modulus, value), tracking the magnitude of value's
	// coefficient; its sign alternates with the step count.
	function automatic res_item_t mod_inverse(input logic [W-1:0] a, input logic [W-1:0] n);
		longint unsigned r0, r1, c0, c1, q, rem, nxt, mag, n64, inv;
		int unsigned     steps;
		res_item_t       r;
		r = '0;
		if (a == '0 || n == '0)
			return r;
		n64   = longint'(n);
		r0    = n64;
		r1    = longint'(a);
		c0    = 0;
		c1    = 1;
		steps = 1;
		while (r1 != 0) begin
			q     = r0 / r1;
			rem   = r0 % r1;
			r0    = r1;
			r1    = rem;
			nxt   = c0 + q * c1;
			c0    = c1;
			c1    = nxt;
			steps++;
		end
		if (r0 != 1)
			return r;
		mag = c0 % n64;
		if (((steps - 1) & 1) != 0)
			inv = mag;
		else
			inv = (mag == 0) ? 0 : (n64 - mag);
		r.inverse = inv[W-1:0];
		r.exists  = 1'b1;
		return r;
	endfunction

	function automatic logic [W-1:0] rand_bits(input int nbits);
		logic [31:0] x;
		x = $urandom;
		x = x & ((32'h1 << nbits) - 32'h1);
		return x[W-1:0];
	endfunction

	task automatic add_item(input logic [W-1:0] v, input logic [W-1:0] m);
		src_item_t it;
		it.value   = v;
		it.modulus = m;
		operand_q.push_back(it);
	endtask

	task automatic add_random_items(input int count);
		logic [W-1:0] v, m, x, y;
		int           kind, f;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			if (kind < 50) begin
				v = rand_bits($urandom_range(1, W));
				m = rand_bits($urandom_range(1, W));
			end else if (kind < 65) begin
				v = rand_bits(W);
				m = rand_bits(W);
			end else if (kind < 80) begin
				// shared factor, so no inverse
				f = $urandom_range(2, 60);
				x = rand_bits($urandom_range(1, 24));
				y = rand_bits($urandom_range(1, 24)) + W'(1);
				v = W'(f * x);
				m = W'(f * y);
			end else if (kind < 90) begin
				v = rand_bits(W);
				m = WMAX;
			end else if (kind < 95) begin
				v = ($urandom_range(1) == 0) ? '0 : rand_bits(W);
				m = W'($urandom_range(1));
			end else begin
				v = rand_bits(W);
				m = rand_bits($urandom_range(1, 8));
			end
			add_item(v, m);
		end
	endtask

	// sender holds off until every outstanding result is back
	task automatic wait_drained();
		while (operand_q.size() != 0 || src_valid || inverse_q.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_data  <= '0;
		end else begin
			if (src_valid && !src_stall) begin
				inverse_q.push_back(mod_inverse(src_data.value, src_data.modulus));
				n_accepted++;
			end
			if (!src_valid || !src_stall) begin
				if (operand_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					src_data  <= operand_q.pop_front();
					src_valid <= 1'b1;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(99) < res_stall_pct);
			if (res_valid && !res_stall) begin
				n_results++;
				if (inverse_q.size() == 0) begin
					$display("%0t: unexpected result inverse=%0d exists=%0d",
						$time, res_data.inverse, res_data.exists);
					err_cnt++;
				end else begin
					want = inverse_q.pop_front();
					if (want.exists)
						n_exist++;
					if (res_data.inverse !== want.inverse) begin
						$display("%0t: inverse mismatch, expected %0d actual %0d",
							$time, want.inverse, res_data.inverse);
						err_cnt++;
					end
					if (res_data.exists !== want.exists) begin
						$display("%0t: exists mismatch, expected %0d actual %0d",
							$time, want.exists, res_data.exists);
						err_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero operands, modulus one and zero, extremes,
		// worst-case Fibonacci pair, value at or above modulus, shared factors
		add_item('0, 31'd1);
		add_item('0, WMAX);
		add_item(31'd1, 31'd1);
		add_item(31'd12345, 31'd1);
		add_item(31'd7, '0);
		add_item('0, '0);
		add_item(WMAX, WMAX);
		add_item(WMAX - 31'd1, WMAX);
		add_item(31'd1, WMAX);
		add_item(31'd2, WMAX);
		add_item(31'd1134903170, 31'd1836311903);
		add_item(31'd1836311903, 31'd1134903170);
		add_item(31'd3, 31'd7);
		add_item(31'd10, 31'd7);
		add_item(31'd7, 31'd7);
		add_item(31'd6, 31'd9);
		add_item(31'd2, 31'd4);
		add_item(WMAX, 31'd2);
		add_item(31'h5555_5555, 31'h2AAA_AAAA);
		add_item(31'h2AAA_AAAA, 31'h5555_5555);
		add_item(31'd1, 31'd2);
		add_item(31'h4000_0000, WMAX);
		add_item(WMAX, 31'h4000_0000);
		add_item(31'd65536, 31'd65537);
		wait_drained();

		add_random_items(BATCH);
		wait_drained();

		// second batch opens with a stretch of no idling on either side
		add_random_items(BATCH);
		src_idle_pct  = 0;
		res_stall_pct = 0;
		while (n_accepted < 24 + BATCH + 100)
			@(negedge clk);
		src_idle_pct  = IDLE_PCT;
		res_stall_pct = IDLE_PCT;
		wait_drained();

		$display("%0d items sent, %0d results checked, %0d with an inverse",
			n_accepted, n_results, n_exist);
		$display("covered zero and unit moduli, extremes, shared factors, random widths");
		if (err_cnt == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("%0d errors found", err_cnt);
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/mi_pkg.sv
src/mi_dp.sv
src/mi_ctrl.sv
src/modular_inverse_top.sv
src/mi_checker.sv
bench/tb_top.sv
